[src/mdcr_pkg.sv]
`default_nettype none

package mdcr_pkg;

   // default duty resolution
   localparam int DUTY_BITS_DEF = 13;

   // ramp time and elapsed counter width, also the q0.x fraction of t
   localparam int TIME_BITS = 16;

   // update interval register
   localparam int INTERVAL_BITS = 8;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(10);

   // item opcodes
   localparam logic OP_CMD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

endpackage

`default_nettype wire

[src/mdcr_req_if.sv]
`default_nettype none

interface mdcr_req_if #(
   parameter int DUTY_BITS = mdcr_pkg::DUTY_BITS_DEF
) ();
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic                           enable;
   logic [DUTY_BITS-1:0]           start_duty;
   logic [DUTY_BITS-1:0]           end_duty;
   logic [mdcr_pkg::TIME_BITS-1:0] ramp_ticks;

   modport source (
      output valid, op, enable, start_duty, end_duty, ramp_ticks,
      input  ready
   );

   modport sink (
      input  valid, op, enable, start_duty, end_duty, ramp_ticks,
      output ready
   );
endinterface

`default_nettype wire

[src/mdcr_rsp_if.sv]
`default_nettype none

interface mdcr_rsp_if #(
   parameter int DUTY_BITS = mdcr_pkg::DUTY_BITS_DEF
) ();
   logic                 valid;
   logic                 ready;
   logic [DUTY_BITS-1:0] duty;
   logic                 motor_enabled;
   logic                 ramping;

   modport source (
      output valid, duty, motor_enabled, ramping,
      input  ready
   );

   modport sink (
      input  valid, duty, motor_enabled, ramping,
      output ready
   );
endinterface

`default_nettype wire

[src/motor_duty_cubic_ramp_core.sv]
`default_nettype none
// commands and most ticks: result registered, valid the cycle after accept
// a tick that recomputes the duty runs a bit-serial
//   restoring divide and three bit-serial shift-add multiplies, 16 steps each
// throughput: one item per cycle without recompute or result back-pressure
// reset: synchronous active high, clears ramp state and duty, interval = 10

module motor_duty_cubic_ramp_core #(
   parameter int DUTY_BITS = mdcr_pkg::DUTY_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   mdcr_req_if.sink                            req_bus,
   mdcr_rsp_if.source                          rsp_bus,
   input  wire                                 csr_we,
   input  wire [mdcr_pkg::INTERVAL_BITS-1:0]   csr_wdata
);

   localparam int TB = mdcr_pkg::TIME_BITS;
   localparam int IB = mdcr_pkg::INTERVAL_BITS;
   // multiplicand width: wide enough for t and for the duty span
   localparam int MW = (DUTY_BITS > TB) ? DUTY_BITS : TB;
   localparam int AW = MW + TB;
   localparam int CNT_BITS = $clog2(TB);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(TB - 1);
   localparam logic [TB-1:0] ELAPSED_MAX = {TB{1'b1}};

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV  = 5'b00010,
      S_MUL1 = 5'b00100,
      S_MUL2 = 5'b01000,
      S_MUL3 = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // ramp state
   logic [TB-1:0]        elapsed_ff, elapsed_in;
   logic [IB-1:0]        intv_cnt_ff, intv_cnt_in;
   logic                 active_ff, active_in;
   logic                 enabled_ff, enabled_in;
   logic [DUTY_BITS-1:0] start_ff, start_in;
   logic [DUTY_BITS-1:0] target_ff, target_in;
   logic [TB-1:0]        rtime_ff, rtime_in;
   logic [DUTY_BITS-1:0] duty_ff, duty_in;
   logic [IB-1:0]        cfg_intv_ff, cfg_intv_in;

   // serial arithmetic
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [TB-1:0]        rem_ff, rem_in;
   logic [TB-1:0]        q_ff, q_in;
   logic [MW-1:0]        a_ff, a_in;
   logic [TB-1:0]        b_ff, b_in;
   logic [AW-1:0]        acc_ff, acc_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DUTY_BITS-1:0] rsp_duty_ff, rsp_duty_in;
   logic                 rsp_en_ff, rsp_en_in;
   logic                 rsp_ramp_ff, rsp_ramp_in;

   logic                 accept;
   logic                 last;
   logic [TB:0]          rem_sh;
   logic                 div_ge;
   logic [MW:0]          mul_sum;
   logic [AW-1:0]        acc_step;
   logic [TB-1:0]        tick_elapsed;
   logic [IB-1:0]        tick_intv;
   logic [IB-1:0]        intv_lim;
   logic                 ramp_up;
   logic [DUTY_BITS-1:0] span;
   logic [MW:0]          step_wide;
   logic [DUTY_BITS-1:0] step;

   // new item only when idle and the result slot is free or draining
   assign req_bus.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign last          = (cnt_ff == CNT_LAST);

   // one restoring divide step: remainder stays below the ramp time
   assign rem_sh = {rem_ff, 1'b0};
   assign div_ge = (rem_sh >= {1'b0, rtime_ff});

   // one shift-add multiply step, multiplier bits lsb first
   assign mul_sum  = {1'b0, acc_ff[AW-1:TB]} + (b_ff[0] ? {1'b0, a_ff} : '0);
   assign acc_step = {mul_sum, acc_ff[TB-1:1]};

   // tick bookkeeping, saturating elapsed count, zero interval acts as one
   assign tick_elapsed = (elapsed_ff != ELAPSED_MAX) ? elapsed_ff + 1'b1 : elapsed_ff;
   assign tick_intv    = intv_cnt_ff + 1'b1;
   assign intv_lim     = (cfg_intv_ff == '0) ? IB'(1) : cfg_intv_ff;

   // signed span as direction plus magnitude
   assign ramp_up   = (target_ff >= start_ff);
   assign span      = ramp_up ? target_ff - start_ff : start_ff - target_ff;
   // round half away from zero on the magnitude
   assign step_wide = {1'b0, acc_step[AW-1:TB]} + {{MW{1'b0}}, acc_step[TB-1]};
   assign step      = step_wide[DUTY_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      intv_cnt_in  = intv_cnt_ff;
      active_in    = active_ff;
      enabled_in   = enabled_ff;
      start_in     = start_ff;
      target_in    = target_ff;
      rtime_in     = rtime_ff;
      duty_in      = duty_ff;
      cfg_intv_in  = csr_we ? csr_wdata : cfg_intv_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      q_in         = q_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_duty_in  = rsp_duty_ff;
      rsp_en_in    = rsp_en_ff;
      rsp_ramp_in  = rsp_ramp_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // result goes out now unless a recompute is started below
               rsp_valid_in = 1'b1;
               if (req_bus.op == mdcr_pkg::OP_CMD) begin
                  enabled_in = req_bus.enable;
                  if (req_bus.enable) begin
                     start_in    = req_bus.start_duty;
                     target_in   = req_bus.end_duty;
                     rtime_in    = req_bus.ramp_ticks;
                     elapsed_in  = '0;
                     intv_cnt_in = '0;
                     if (req_bus.ramp_ticks == '0) begin
                        duty_in   = req_bus.end_duty;
                        active_in = 1'b0;
                     end else begin
                        duty_in   = req_bus.start_duty;
                        active_in = 1'b1;
                     end
                  end else begin
                     // standby keeps the duty
                     active_in = 1'b0;
                  end
               end else if (active_ff) begin
                  elapsed_in  = tick_elapsed;
                  intv_cnt_in = tick_intv;
                  // end of ramp wins over recompute
                  if ((rtime_ff == '0) || (tick_elapsed >= rtime_ff)) begin
                     duty_in   = target_ff;
                     active_in = 1'b0;
                  end else if (tick_intv >= intv_lim) begin
                     intv_cnt_in  = '0;
                     rsp_valid_in = 1'b0;
                     rem_in       = tick_elapsed;
                     q_in         = '0;
                     cnt_in       = '0;
                     state_in     = S_DIV;
                  end
               end
               rsp_duty_in = duty_in;
               rsp_en_in   = enabled_in;
               rsp_ramp_in = active_in;
            end
         end

         S_DIV: begin
            // t = floor(elapsed * 2^16 / ramp time), one quotient bit a cycle
            rem_in = div_ge ? TB'(rem_sh - {1'b0, rtime_ff}) : rem_sh[TB-1:0];
            q_in   = {q_ff[TB-2:0], div_ge};
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               a_in     = MW'({q_ff[TB-2:0], div_ge});
               b_in     = {q_ff[TB-2:0], div_ge};
               acc_in   = '0;
               state_in = S_MUL1;
            end
         end

         S_MUL1: begin
            // t * t, keep the upper half as t2
            acc_in = acc_step;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               a_in     = MW'(q_ff);
               b_in     = acc_step[2*TB-1:TB];
               acc_in   = '0;
               state_in = S_MUL2;
            end
         end

         S_MUL2: begin
            // t2 * t, upper half is the eased fraction e
            acc_in = acc_step;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               a_in     = MW'(span);
               b_in     = acc_step[2*TB-1:TB];
               acc_in   = '0;
               state_in = S_MUL3;
            end
         end

         S_MUL3: begin
            // |span| * e, then rounded step applied toward the target
            acc_in = acc_step;
            b_in   = b_ff >> 1;
            cnt_in = cnt_ff + 1'b1;
            if (last) begin
               duty_in      = ramp_up ? start_ff + step : start_ff - step;
               rsp_valid_in = 1'b1;
               rsp_duty_in  = duty_in;
               rsp_en_in    = enabled_ff;
               rsp_ramp_in  = active_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         elapsed_ff   <= '0;
         intv_cnt_ff  <= '0;
         active_ff    <= 1'b0;
         enabled_ff   <= 1'b0;
         start_ff     <= '0;
         target_ff    <= '0;
         rtime_ff     <= '0;
         duty_ff      <= '0;
         cfg_intv_ff  <= mdcr_pkg::INTERVAL_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         elapsed_ff   <= elapsed_in;
         intv_cnt_ff  <= intv_cnt_in;
         active_ff    <= active_in;
         enabled_ff   <= enabled_in;
         start_ff     <= start_in;
         target_ff    <= target_in;
         rtime_ff     <= rtime_in;
         duty_ff      <= duty_in;
         cfg_intv_ff  <= cfg_intv_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      acc_ff      <= acc_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_en_ff   <= rsp_en_in;
      rsp_ramp_ff <= rsp_ramp_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.duty          = rsp_duty_ff;
   assign rsp_bus.motor_enabled = rsp_en_ff;
   assign rsp_bus.ramping       = rsp_ramp_ff;

   // no new item while the serial math runs
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req_bus.ready)
      else $error("item accepted during duty recompute");

   // a recompute only runs inside an active ramp
   a_busy_active: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (active_ff && enabled_ff))
      else $error("recompute running outside a ramp");

   // finishing the last multiply presents a result
   a_done_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MUL3) && last) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("recompute finished without a result");

   // a recompute starts with the result slot empty
   a_start_empty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && (state_in == S_DIV)) |=> !rsp_valid_ff)
      else $error("result pending while recompute starts");

endmodule

`default_nettype wire
